/* rtl/core/ctat_pkg.sv */
// ----------------------------------------------------------------------------
// ctat_pkg
// Shared types and constants for the client table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package ctat_pkg;

  localparam int unsigned NumEntries = 64;
  localparam int unsigned IdxW       = $clog2(NumEntries);
  localparam int unsigned CntW       = IdxW + 1;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned TokW   = 64;
  localparam int unsigned EidxW  = 6;
  localparam int unsigned StatW  = 3;
  localparam int unsigned UsageW = 32;
  localparam int unsigned StaleW = 32;
  localparam int unsigned RateW  = 16;
  localparam int unsigned LimitW = 32;
  localparam int unsigned DecW   = TimeW + RateW;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [StaleW-1:0] StaleReset = 32'd30000;
  localparam logic [RateW-1:0]  RateReset  = 16'd1;
  localparam logic [LimitW-1:0] LimitReset = 32'd65536;

  localparam logic [CmdW-1:0] CmdInsert = 2'd0;
  localparam logic [CmdW-1:0] CmdRemove = 2'd1;
  localparam logic [CmdW-1:0] CmdCheck  = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgStale = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRate  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLimit = 2'd2;

  typedef enum logic [StatW-1:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_ABSENT   = 3'd5,
    ST_CHECKED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CHECK  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // classified request as held in the queue
  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] now;
    logic             blocked;
    logic [TokW-1:0]  token;
    logic [IdxW-1:0]  idx;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [EidxW-1:0]  index;
    logic [TokW-1:0]   token;
    logic              ok;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/ctat_if.sv */
// ----------------------------------------------------------------------------
// ctat_if
// Request, response and configuration channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctat_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] addr;
  logic [47:0] now_ms;
  logic        blocked;
  logic [63:0] new_token;
  logic [5:0]  entry_index;
  modport source (output valid, command, addr, now_ms, blocked, new_token, entry_index,
                  input ready);
  modport sink   (input valid, command, addr, now_ms, blocked, new_token, entry_index,
                  output ready);
endinterface

interface ctat_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  result_index;
  logic [63:0] entry_token;
  logic        bandwidth_ok;
  modport source (output valid, status, result_index, entry_token, bandwidth_ok,
                  input ready);
  modport sink   (input valid, status, result_index, entry_token, bandwidth_ok,
                  output ready);
endinterface

interface ctat_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/ctat_front.sv */
// ----------------------------------------------------------------------------
// ctat_front
// Accepts requests, classifies the command and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ctat_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ctat_req_if.sink           req,
  output ctat_pkg::req_t     q_data_o,
  output logic               q_valid_o,
  input  wire logic          q_pop_i
);
  import ctat_pkg::*;

  req_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  req_t       cls;
  logic       push;
  logic       pop;

  always_comb begin
    cls.addr    = req.addr;
    cls.now     = req.now_ms;
    cls.blocked = req.blocked;
    cls.token   = req.new_token;
    cls.idx     = IdxW'(req.entry_index);
    case (req.command)
      CmdInsert: cls.op = OP_INSERT;
      CmdRemove: cls.op = OP_REMOVE;
      CmdCheck: begin
        // out-of-range entry answers absent
        if ({26'd0, req.entry_index} < 32'(NumEntries)) cls.op = OP_CHECK;
        else cls.op = OP_NONE;
      end
      default: cls.op = OP_NONE;
    endcase
  end

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cls;
  end

endmodule

`default_nettype wire

/* rtl/core/ctat_back.sv */
// ----------------------------------------------------------------------------
// ctat_back
// Table engine: entry memories, sequential key scan, bandwidth drain and
// the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ctat_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  ctat_pkg::req_t     q_data_i,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  ctat_cfg_if.sink           cfg,
  ctat_rsp_if.source         rsp
);
  import ctat_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_CK_RD   = 7'b0000100,
    S_CK_DIFF = 7'b0001000,
    S_CK_MUL  = 7'b0010000,
    S_CK_SUB  = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q, req_d;
  rsp_t   res_q, res_d;
  rsp_t   out_q, out_d;
  logic   out_vld_q, out_vld_d;

  logic [StaleW-1:0] stale_q;
  logic [RateW-1:0]  rate_q;
  logic [LimitW-1:0] limit_q;

  logic [NumEntries-1:0] linked_q, linked_d;
  logic [CntW-1:0]       fill_q, fill_d;
  logic [CntW-1:0]       scan_cnt_q, scan_cnt_d;
  logic [IdxW-1:0]       cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic                  stale_fnd_q, stale_fnd_d;
  logic [IdxW-1:0]       stale_idx_q, stale_idx_d;
  logic [TimeW-1:0]      diff_q, diff_d;
  logic                  pos_q, pos_d;
  logic [DecW-1:0]       dec_q, dec_d;

  // entry memories
  logic [AddrW-1:0]  key_mem   [NumEntries];
  logic [TimeW-1:0]  stamp_mem [NumEntries];
  logic [UsageW-1:0] usage_mem [NumEntries];
  logic [TokW-1:0]   tok_mem   [NumEntries];
  logic [AddrW-1:0]  key_rd_q;
  logic [TimeW-1:0]  stamp_rd_q;
  logic [UsageW-1:0] usage_rd_q;
  logic [TokW-1:0]   tok_rd_q;

  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_addr;
  logic              key_we, tok_we, stamp_we, usage_we;
  logic [TimeW-1:0]  stamp_wd;
  logic [UsageW-1:0] usage_wd;

  logic              match;
  logic              stale_hit;
  logic              stale_any;
  logic [IdxW-1:0]   stale_sel;
  logic [IdxW-1:0]   slot;
  logic              out_free;

  assign rd_addr   = state_q == S_SCAN ? scan_cnt_q[IdxW-1:0] : req_q.idx;
  assign match     = cmp_vld_q && linked_q[cmp_idx_q] && (key_rd_q == req_q.addr);
  assign stale_hit = (req_q.now >= stamp_rd_q) &&
                     ((req_q.now - stamp_rd_q) > {16'd0, stale_q});
  assign out_free  = !out_vld_q || rsp.ready;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q && !rsp.ready;
    linked_d    = linked_q;
    fill_d      = fill_q;
    scan_cnt_d  = scan_cnt_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_vld_d   = 1'b0;
    stale_fnd_d = stale_fnd_q;
    stale_idx_d = stale_idx_q;
    diff_d      = diff_q;
    pos_d       = pos_q;
    dec_d       = dec_q;
    q_pop_o     = 1'b0;
    wr_addr     = req_q.idx;
    key_we      = 1'b0;
    tok_we      = 1'b0;
    stamp_we    = 1'b0;
    usage_we    = 1'b0;
    stamp_wd    = req_q.now;
    usage_wd    = '0;
    stale_any   = stale_fnd_q;
    stale_sel   = stale_idx_q;
    slot        = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o     = 1'b1;
          req_d       = q_data_i;
          scan_cnt_d  = '0;
          stale_fnd_d = 1'b0;
          case (q_data_i.op)
            OP_INSERT, OP_REMOVE: state_d = S_SCAN;
            OP_CHECK:             state_d = S_CK_RD;
            default: begin
              res_d   = '{status: ST_ABSENT, index: '0, token: '0, ok: 1'b0};
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read issue runs one entry ahead of the compare
        if (scan_cnt_q < CntW'(NumEntries)) begin
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
        if (cmp_vld_q) begin
          if (!stale_fnd_q && stale_hit) begin
            stale_any = 1'b1;
            stale_sel = cmp_idx_q;
          end
          stale_fnd_d = stale_any;
          stale_idx_d = stale_sel;
          if (match) begin
            cmp_vld_d = 1'b0;
            state_d   = S_DONE;
            if (req_q.op == OP_REMOVE) begin
              linked_d[cmp_idx_q] = 1'b0;
              res_d = '{status: ST_REMOVED, index: EidxW'(cmp_idx_q),
                        token: tok_rd_q, ok: 1'b0};
            end else begin
              res_d = '{status: ST_FOUND, index: EidxW'(cmp_idx_q),
                        token: tok_rd_q, ok: 1'b0};
            end
          end else if (cmp_idx_q == IdxW'(NumEntries - 1)) begin
            cmp_vld_d = 1'b0;
            state_d   = S_DONE;
            if (req_q.op == OP_REMOVE) begin
              res_d = '{status: ST_ABSENT, index: '0, token: '0, ok: 1'b0};
            end else if (req_q.blocked) begin
              res_d = '{status: ST_BLOCKED, index: '0, token: '0, ok: 1'b0};
            end else if (fill_q < CntW'(NumEntries) || stale_any) begin
              if (fill_q < CntW'(NumEntries)) begin
                slot   = fill_q[IdxW-1:0];
                fill_d = fill_q + 1'b1;
              end else begin
                slot = stale_sel;
              end
              // overwriting the slot unlinks its old address
              wr_addr        = slot;
              key_we         = 1'b1;
              tok_we         = 1'b1;
              stamp_we       = 1'b1;
              usage_we       = 1'b1;
              linked_d[slot] = 1'b1;
              res_d = '{status: ST_INSERTED, index: EidxW'(slot),
                        token: req_q.token, ok: 1'b0};
            end else begin
              res_d = '{status: ST_FULL, index: '0, token: '0, ok: 1'b0};
            end
          end
        end
      end

      S_CK_RD: state_d = S_CK_DIFF;

      S_CK_DIFF: begin
        diff_d   = req_q.now - stamp_rd_q;
        pos_d    = req_q.now > stamp_rd_q;
        stamp_we = 1'b1;
        state_d  = S_CK_MUL;
      end

      S_CK_MUL: begin
        dec_d   = diff_q * {{(DecW-RateW){1'b0}}, rate_q};
        state_d = S_CK_SUB;
      end

      S_CK_SUB: begin
        if (!pos_q) usage_wd = usage_rd_q;
        else if ({{(DecW-UsageW){1'b0}}, usage_rd_q} > dec_q)
          usage_wd = usage_rd_q - dec_q[UsageW-1:0];
        else usage_wd = '0;
        usage_we = 1'b1;
        res_d = '{status: ST_CHECKED, index: EidxW'(req_q.idx), token: tok_rd_q,
                  ok: (usage_wd < limit_q)};
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_vld_q   <= 1'b0;
      linked_q    <= '0;
      fill_q      <= '0;
      cmp_vld_q   <= 1'b0;
      stale_fnd_q <= 1'b0;
      stale_q     <= StaleReset;
      rate_q      <= RateReset;
      limit_q     <= LimitReset;
    end else begin
      state_q     <= state_d;
      out_vld_q   <= out_vld_d;
      linked_q    <= linked_d;
      fill_q      <= fill_d;
      cmp_vld_q   <= cmp_vld_d;
      stale_fnd_q <= stale_fnd_d;
      if (cfg.valid) begin
        case (cfg.index)
          CfgStale: stale_q <= cfg.data;
          CfgRate:  rate_q  <= cfg.data[RateW-1:0];
          CfgLimit: limit_q <= cfg.data;
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    res_q       <= res_d;
    out_q       <= out_d;
    scan_cnt_q  <= scan_cnt_d;
    cmp_idx_q   <= cmp_idx_d;
    stale_idx_q <= stale_idx_d;
    diff_q      <= diff_d;
    pos_q       <= pos_d;
    dec_q       <= dec_d;
  end

  always_ff @(posedge clk_i) begin
    if (key_we)   key_mem[wr_addr]   <= req_q.addr;
    if (tok_we)   tok_mem[wr_addr]   <= req_q.token;
    if (stamp_we) stamp_mem[wr_addr] <= stamp_wd;
    if (usage_we) usage_mem[wr_addr] <= usage_wd;
    key_rd_q   <= key_mem[rd_addr];
    tok_rd_q   <= tok_mem[rd_addr];
    stamp_rd_q <= stamp_mem[rd_addr];
    usage_rd_q <= usage_mem[rd_addr];
  end

  assign cfg.ready        = 1'b1;
  assign rsp.valid        = out_vld_q;
  assign rsp.status       = out_q.status;
  assign rsp.result_index = out_q.index;
  assign rsp.entry_token  = out_q.token;
  assign rsp.bandwidth_ok = out_q.ok;

endmodule

`default_nettype wire

/* rtl/core/client_table_with_aging_top.sv */
// Insert and remove scan the key memory one entry per cycle and stop at the
// first linked match; a bandwidth check steps through memory read, subtract,
// multiply and drain. The engine takes one request at a time: it pops the next
// request only after the previous response has been registered.
// Reset restores config defaults and clears link flags and fill count; the
// entry memories are not cleared.
// ----------------------------------------------------------------------------
// client_table_with_aging_top
// Client table with timeout reuse and bandwidth drain.
// ----------------------------------------------------------------------------
`default_nettype none

module client_table_with_aging_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ctat_req_if.sink    req,
  ctat_rsp_if.source  rsp,
  ctat_cfg_if.sink    cfg
);
  import ctat_pkg::*;

  req_t q_data;
  logic q_valid;
  logic q_pop;

  ctat_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .q_data_o (q_data),
    .q_valid_o(q_valid),
    .q_pop_i  (q_pop)
  );

  ctat_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_data_i (q_data),
    .q_valid_i(q_valid),
    .q_pop_o  (q_pop),
    .cfg      (cfg),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

/* rtl/core/ctat_chk.sv */
// ----------------------------------------------------------------------------
// ctat_chk
// Port-level checks on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ctat_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [2:0]  status_i,
  input wire logic [5:0]  result_index_i,
  input wire logic [63:0] entry_token_i,
  input wire logic        bandwidth_ok_i
);
  import ctat_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(entry_token_i))
    else $error("response changed while stalled");

  a_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FOUND || status_i == ST_INSERTED ||
      status_i == ST_REMOVED) |-> !bandwidth_ok_i)
    else $error("bandwidth_ok set on table response");

  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_BLOCKED || status_i == ST_FULL ||
      status_i == ST_ABSENT) |-> result_index_i == '0 && entry_token_i == '0 &&
      !bandwidth_ok_i)
    else $error("refusal carries nonzero fields");

  a_rst_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("response valid out of reset");

endmodule

bind client_table_with_aging_top ctat_chk u_ctat_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .status_i      (rsp.status),
  .result_index_i(rsp.result_index),
  .entry_token_i (rsp.entry_token),
  .bandwidth_ok_i(rsp.bandwidth_ok)
);

`default_nettype wire

/* tb/ctat_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctat_checker
// Watches the request, response and configuration channels, keeps a
// shadow copy of the client table, predicts every response and compares it.
// ----------------------------------------------------------------------------

module ctat_checker
  import ctat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ctat_req_if         req,
  ctat_rsp_if         rsp,
  ctat_cfg_if         cfg,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output logic [63:0] written_o
);

  typedef struct {
    status_e          status;
    logic [EidxW-1:0] index;
    logic [TokW-1:0]  token;
    logic             ok;
  } table_reply_t;

  logic [AddrW-1:0]  shadow_key   [NumEntries];
  logic              shadow_link  [NumEntries];
  logic [TimeW-1:0]  shadow_stamp [NumEntries];
  logic [UsageW-1:0] shadow_usage [NumEntries];
  logic [TokW-1:0]   shadow_token [NumEntries];
  int                fill_cnt;
  logic [StaleW-1:0] stale_age;
  logic [RateW-1:0]  drain_rate;
  logic [LimitW-1:0] bw_limit;

  table_reply_t expected_q[$];

  function automatic int find_linked(logic [AddrW-1:0] key);
    for (int i = 0; i < NumEntries; i++) begin
      if (shadow_link[i] && shadow_key[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic table_reply_t run_command(logic [CmdW-1:0] cmd, logic [AddrW-1:0] addr,
                                               logic [TimeW-1:0] now, logic blk,
                                               logic [TokW-1:0] tok,
                                               logic [EidxW-1:0] eidx);
    table_reply_t r;
    int           slot;
    logic [63:0]  drain;
    logic [TimeW-1:0] old;
    r = '{ST_ABSENT, '0, '0, 1'b0};
    if (cmd == CmdInsert) begin
      slot = find_linked(addr);
      if (slot >= 0) begin
        r = '{ST_FOUND, slot[EidxW-1:0], shadow_token[slot], 1'b0};
      end else if (blk) begin
        r = '{ST_BLOCKED, '0, '0, 1'b0};
      end else begin
        if (fill_cnt < NumEntries) begin
          slot = fill_cnt;
          fill_cnt++;
        end else begin
          for (int i = 0; i < NumEntries; i++) begin
            if (slot < 0 && now >= shadow_stamp[i] &&
                (now - shadow_stamp[i]) > {16'd0, stale_age}) slot = i;
          end
        end
        if (slot < 0) begin
          r = '{ST_FULL, '0, '0, 1'b0};
        end else begin
          shadow_key[slot]   = addr;
          shadow_token[slot] = tok;
          shadow_stamp[slot] = now;
          shadow_usage[slot] = '0;
          shadow_link[slot]  = 1'b1;
          written_o[slot]    = 1'b1;
          r = '{ST_INSERTED, slot[EidxW-1:0], tok, 1'b0};
        end
      end
    end else if (cmd == CmdRemove) begin
      slot = find_linked(addr);
      if (slot >= 0) begin
        shadow_link[slot] = 1'b0;
        r = '{ST_REMOVED, slot[EidxW-1:0], shadow_token[slot], 1'b0};
      end
    end else if (cmd == CmdCheck) begin
      old = shadow_stamp[eidx];
      shadow_stamp[eidx] = now;
      if (now > old) begin
        drain = 64'(now - old) * 64'(drain_rate);
        if (64'(shadow_usage[eidx]) > drain) shadow_usage[eidx] -= drain[31:0];
        else shadow_usage[eidx] = '0;
      end
      r = '{ST_CHECKED, eidx, shadow_token[eidx], shadow_usage[eidx] < bw_limit};
    end
    return r;
  endfunction

  // Handshakes are sampled at the falling edge; they complete at the next rising one.
  always @(negedge clk_i or negedge rst_ni) begin
    table_reply_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NumEntries; i++) begin
        shadow_key[i]   = '0;
        shadow_link[i]  = 1'b0;
        shadow_stamp[i] = '0;
        shadow_usage[i] = '0;
        shadow_token[i] = '0;
      end
      fill_cnt     = 0;
      stale_age    = StaleReset;
      drain_rate   = RateReset;
      bw_limit     = LimitReset;
      written_o    = '0;
      fail_count_o = 0;
      checked_o    = 0;
      expected_q.delete();
      pending_o    = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CfgStale: stale_age  = cfg.data;
          CfgRate:  drain_rate = cfg.data[RateW-1:0];
          CfgLimit: bw_limit   = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        expected_q.push_back(run_command(req.command, req.addr, req.now_ms, req.blocked,
                                         req.new_token, req.entry_index));
      end
      if (rsp.valid && rsp.ready) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          $error("unexpected response: status %0d", rsp.status);
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            fail_count_o++;
          end
          if (rsp.result_index !== e.index) begin
            $error("result_index: expected %0d, got %0d", e.index, rsp.result_index);
            fail_count_o++;
          end
          if (rsp.entry_token !== e.token) begin
            $error("entry_token: expected %h, got %h", e.token, rsp.entry_token);
            fail_count_o++;
          end
          if (rsp.bandwidth_ok !== e.ok) begin
            $error("bandwidth_ok: expected %0d, got %0d", e.ok, rsp.bandwidth_ok);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests and register writes into the client table through several
// register settings and random idling; the checker judges every response.
// ----------------------------------------------------------------------------

module testbench;
  import ctat_pkg::*;

  localparam logic [CmdW-1:0] CmdUnknown = 2'd3;
  localparam int unsigned     CycleLimit = 600000;
  localparam int unsigned     PoolSize   = 96;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctat_req_if req ();
  ctat_rsp_if rsp ();
  ctat_cfg_if cfg ();

  int          fail_count;
  int          pending;
  int          checked;
  logic [63:0] written;
  int          cycles = 0;
  int          sent = 0;
  logic        hold_rsp = 1'b0;
  logic        no_idle = 1'b0;
  logic        wide_time = 1'b0;
  logic [AddrW-1:0] addr_pool [PoolSize];
  logic [TimeW-1:0] clock_ms = '0;

  always #2 clk_i = ~clk_i;

  client_table_with_aging_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg)
  );

  ctat_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .rsp          (rsp),
    .cfg          (cfg),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .written_o    (written)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // response side: random back-pressure, plus one long hold-off on demand
  initial begin
    int n;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          rsp.ready <= 1'b0;
          repeat (n - 1) @(posedge clk_i);
          @(posedge clk_i);
        end
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(logic [CmdW-1:0] cmd, logic [AddrW-1:0] addr,
                          logic [TimeW-1:0] now, logic blk, logic [TokW-1:0] tok,
                          logic [EidxW-1:0] eidx);
    int n;
    req.valid       <= 1'b1;
    req.command     <= cmd;
    req.addr        <= addr;
    req.now_ms      <= now;
    req.blocked     <= blk;
    req.new_token   <= tok;
    req.entry_index <= eidx;
    do @(negedge clk_i); while (!req.ready);
    @(posedge clk_i);
    sent++;
    n = gap_len();
    if (n > 0) begin
      req.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(negedge clk_i); while (!cfg.ready);
    @(posedge clk_i);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [31:0] stale, logic [31:0] rate, logic [31:0] limit);
    settle();
    write_reg(CfgStale, stale);
    write_reg(CfgRate, rate);
    write_reg(CfgLimit, limit);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_items(int count, int stall_at);
    int               p;
    int               k;
    logic [CmdW-1:0]  cmd;
    logic [EidxW-1:0] eidx;
    for (int i = 0; i < count; i++) begin
      if (i == stall_at) hold_rsp = 1'b1;
      p = $urandom_range(0, 99);
      if (wide_time) clock_ms = TimeW'({$urandom(), $urandom()} >> 16);
      else if (p < 5) clock_ms = clock_ms - $urandom_range(0, 200);
      else clock_ms = clock_ms + $urandom_range(0, 25);
      eidx = EidxW'($urandom_range(0, 63));
      if (p < 50) cmd = CmdInsert;
      else if (p < 70) cmd = CmdRemove;
      else if (p < 96) cmd = CmdCheck;
      else cmd = CmdUnknown;
      if (cmd == CmdCheck) begin
        // only slots that an insert has already written may be checked
        k = 0;
        while (!written[eidx] && k < 64) begin
          eidx = EidxW'($urandom_range(0, 63));
          k++;
        end
        if (!written[eidx]) cmd = CmdInsert;
      end
      send_req(cmd, addr_pool[$urandom_range(0, PoolSize - 1)], clock_ms,
               $urandom_range(0, 9) == 0, rand64(), eidx);
    end
  endtask

  initial begin
    logic [63:0] a;
    logic [63:0] b;
    req.valid = 1'b0;
    req.command = CmdInsert;
    req.addr = '0;
    req.now_ms = '0;
    req.blocked = 1'b0;
    req.new_token = '0;
    req.entry_index = '0;
    cfg.valid = 1'b0;
    cfg.index = CfgStale;
    cfg.data = '0;
    for (int i = 0; i < PoolSize; i++) addr_pool[i] = rand64();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    a = addr_pool[2];
    b = addr_pool[3];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: every command and the corner cases at reset settings
    send_req(CmdInsert, a, 48'd100, 1'b0, 64'h1111, 6'd0);
    send_req(CmdInsert, a, 48'd101, 1'b1, 64'h2222, 6'd0);
    send_req(CmdInsert, b, 48'd102, 1'b1, 64'h3333, 6'd0);
    send_req(CmdInsert, b, '1, 1'b0, '1, 6'd63);
    send_req(CmdRemove, a, 48'd103, 1'b0, 64'h0, 6'd0);
    send_req(CmdRemove, a, 48'd104, 1'b0, 64'h0, 6'd0);
    send_req(CmdInsert, a, 48'd105, 1'b0, 64'h4444, 6'd0);
    send_req(CmdInsert, a, 48'd106, 1'b0, 64'h5555, 6'd0);
    send_req(CmdCheck, a, 48'd50, 1'b0, 64'h0, 6'd0);
    send_req(CmdCheck, a, '1, 1'b0, 64'h0, 6'd1);
    send_req(CmdCheck, a, 48'd0, 1'b0, 64'h0, 6'd1);
    send_req(CmdUnknown, a, 48'd107, 1'b0, 64'h0, 6'd63);
    send_req(CmdInsert, addr_pool[1], 48'd108, 1'b0, '1, 6'd0);
    send_req(CmdInsert, addr_pool[0], 48'd109, 1'b0, '0, 6'd0);
    send_req(CmdRemove, addr_pool[1], 48'd110, 1'b0, '0, 6'd0);
    send_req(CmdCheck, a, 48'd200000, 1'b0, '0, 6'd3);
    clock_ms = 48'd1000;

    random_items(150, -1);
    set_regs(32'd40, 32'hFFFF, 32'd0);
    random_items(150, 40);
    no_idle = 1'b1;
    set_regs(32'd0, 32'd0, 32'hFFFF_FFFF);
    random_items(100, -1);
    no_idle = 1'b0;
    wide_time = 1'b1;
    set_regs(32'hFFFF_FFFF, $urandom_range(0, 65535), $urandom());
    random_items(100, -1);
    wide_time = 1'b0;
    set_regs($urandom_range(1, 60), $urandom_range(0, 65535), $urandom_range(0, 3));
    random_items(100, -1);
    settle();

    $display("%0d requests sent, %0d responses checked over five register settings",
             sent, checked);
    $display("covered lookup, insert, reuse of stale slots, remove and drain checks");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ctat_pkg.sv
rtl/core/ctat_if.sv
rtl/core/ctat_front.sv
rtl/core/ctat_back.sv
rtl/core/client_table_with_aging_top.sv
rtl/core/ctat_chk.sv
tb/ctat_checker.sv
tb/testbench.sv
